// ----- sv/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants for the bitmap scan and range engine.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int BITS_DEF       = 1024;
  localparam int WORD_WIDTH_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int OFFSET_W = 10;

  typedef enum logic [KIND_W-1:0] {
    K_FIRST_SET   = 3'd0,
    K_LAST_SET    = 3'd1,
    K_FIRST_CLEAR = 3'd2,
    K_LAST_CLEAR  = 3'd3,
    K_SET         = 3'd4,
    K_CLEAR       = 3'd5,
    K_COPY        = 3'd6,
    K_NONE        = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DEC,
    ST_FRD,
    ST_FCHK,
    ST_SRD,
    ST_SWR,
    ST_CRS,
    ST_CRD,
    ST_CWR,
    ST_DONE
  } state_t;

endpackage

// ----- sv/bsr_mem.sv -----
// ----------------------------------------------------------------------------
// bsr_mem
// Bitmap word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bsr_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bitmap_scan_and_range_engine.sv -----
// ----------------------------------------------------------------------------
// bitmap_scan_and_range_engine
// Bitmap with find-first/last, set/clear range and copy range requests.
// ----------------------------------------------------------------------------
// Usage: a request (kind, start_index, bit_count, dest_index) transfers on
// in_valid with in_stall low. One result (found, found_offset, status)
// transfers on out_valid with out_stall low. One request is in work at a
// time; in_stall stays high from acceptance until its result transfers.
// Steps: finds read and check each word scanned; set and clear read and
// write each word touched; copy works bit by bit (the single read port
// is read for the source and the target word, then the target word is
// written); a decode state comes before and a result state after. Zero
// length, kind 7 and out-of-range requests go from decode to the result.
// The engine returns to idle between consecutive requests. Reset: a
// clearing pass writes zero to every word, during which in_stall is high.
// While the receiver stalls, the result holds and no request is taken.
// WORD_WIDTH must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_scan_and_range_engine
  import bsr_pkg::*;
#(
  parameter int BITS       = BITS_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [INDEX_W-1:0]  start_index,
  input  logic [COUNT_W-1:0]  bit_count,
  input  logic [INDEX_W-1:0]  dest_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output logic [OFFSET_W-1:0] found_offset,
  output logic                status
);

  localparam int WORD_COUNT = (BITS + WORD_WIDTH - 1) / WORD_WIDTH;
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PW = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
  localparam int XW = ($clog2(BITS + 1) > 12) ? $clog2(BITS + 1) : 12;

  state_t state, state_next;

  logic [KIND_W-1:0] rq_kind;
  logic [XW-1:0]     rq_start, rq_count, rq_dest;
  logic [AW-1:0]     cur;
  logic [XW-1:0]     k;
  logic              sbit;
  logic              copy_back;

  logic [XW-1:0]     end_idx, off, src_idx, dst_idx;
  logic [XW:0]       src_end, dst_end;
  logic [AW-1:0]     fw, lw, scan_last;
  logic              back, want, range_err, no_op, is_find, is_sc;
  logic [PW-1:0]     lo_pos, hi_pos, hit_pos;
  logic [WORD_WIDTH-1:0] mask, hits, rdata, wdata;
  logic              hit;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [XW-1:0]     hit_idx;

  bsr_mem #(.DEPTH(WORD_COUNT), .WIDTH(WORD_WIDTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // request decode
  always_comb begin
    end_idx   = rq_start + rq_count - XW'(1);
    fw        = rq_start[PW +: AW];
    lw        = end_idx[PW +: AW];
    back      = (rq_kind == K_LAST_SET) || (rq_kind == K_LAST_CLEAR);
    want      = (rq_kind == K_FIRST_SET) || (rq_kind == K_LAST_SET);
    is_find   = (rq_kind == K_FIRST_SET) || (rq_kind == K_LAST_SET) ||
                (rq_kind == K_FIRST_CLEAR) || (rq_kind == K_LAST_CLEAR);
    is_sc     = (rq_kind == K_SET) || (rq_kind == K_CLEAR);
    src_end   = {1'b0, rq_start} + {1'b0, rq_count};
    dst_end   = {1'b0, rq_dest} + {1'b0, rq_count};
    no_op     = (rq_kind == K_NONE) || (rq_count == '0);
    range_err = (src_end > (XW+1)'(BITS)) ||
                ((rq_kind == K_COPY) && (dst_end > (XW+1)'(BITS)));
    scan_last = back ? fw : lw;
  end

  // word mask and priority search
  always_comb begin
    lo_pos = (cur == fw) ? rq_start[PW-1:0] : '0;
    hi_pos = (cur == lw) ? end_idx[PW-1:0] : '1;
    mask   = ({WORD_WIDTH{1'b1}} << lo_pos) &
             ({WORD_WIDTH{1'b1}} >> (PW'(WORD_WIDTH - 1) - hi_pos));
    hits   = (want ? rdata : ~rdata) & mask;
    hit    = |hits;
    hit_pos = '0;
    if (back) begin
      for (int i = 0; i < WORD_WIDTH; i++) begin
        if (hits[i]) hit_pos = PW'(i);
      end
    end else begin
      for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
        if (hits[i]) hit_pos = PW'(i);
      end
    end
    hit_idx = (XW'(cur) << PW) | XW'(hit_pos);
  end

  // copy bit addresses
  always_comb begin
    off     = copy_back ? (rq_count - XW'(1) - k) : k;
    src_idx = rq_start + off;
    dst_idx = rq_dest + off;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:  if (cur == AW'(WORD_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: if (in_valid) state_next = ST_DEC;
      ST_DEC: begin
        priority if (no_op || range_err) state_next = ST_DONE;
        else if (is_find)                state_next = ST_FRD;
        else if (is_sc)                  state_next = ST_SRD;
        else                             state_next = ST_CRS;
      end
      ST_FRD:  state_next = ST_FCHK;
      ST_FCHK: if (hit || cur == scan_last) state_next = ST_DONE;
               else state_next = ST_FRD;
      ST_SRD:  state_next = ST_SWR;
      ST_SWR:  state_next = (cur == lw) ? ST_DONE : ST_SRD;
      ST_CRS:  state_next = ST_CRD;
      ST_CRD:  state_next = ST_CWR;
      ST_CWR:  state_next = (k == rq_count - XW'(1)) ? ST_DONE : ST_CRS;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    we        = 1'b0;
    waddr     = cur;
    wdata     = rdata;
    raddr     = cur;
    unique case (state)
      ST_CLR: begin
        we    = 1'b1;
        wdata = '0;
      end
      ST_SWR: begin
        we    = 1'b1;
        wdata = (rq_kind == K_SET) ? (rdata | mask) : (rdata & ~mask);
      end
      ST_CRS: raddr = src_idx[PW +: AW];
      ST_CRD: raddr = dst_idx[PW +: AW];
      ST_CWR: begin
        we    = 1'b1;
        waddr = dst_idx[PW +: AW];
        wdata = rdata;
        wdata[dst_idx[PW-1:0]] = sbit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      cur   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLR:  cur <= cur + AW'(1);
        ST_DEC:  cur <= (is_find && back) ? lw : fw;
        ST_FCHK: cur <= back ? cur - AW'(1) : cur + AW'(1);
        ST_SWR:  cur <= cur + AW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rq_kind      <= kind;
        rq_start     <= XW'(start_index);
        rq_count     <= XW'(bit_count);
        rq_dest      <= XW'(dest_index);
        found        <= 1'b0;
        found_offset <= '0;
        status       <= 1'b0;
      end
      ST_DEC: begin
        status    <= !no_op && range_err;
        k         <= '0;
        copy_back <= rq_dest > rq_start;
      end
      ST_FCHK: if (hit) begin
        found        <= 1'b1;
        found_offset <= OFFSET_W'(hit_idx - rq_start);
      end
      ST_CRD: sbit <= rdata[src_idx[PW-1:0]];
      ST_CWR: k <= k + XW'(1);
      default: ;
    endcase
  end

endmodule

// ----- tb/bsr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_checker
// Watches both channels of the bitmap engine, keeps its own copy of the
// bitmap, predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module bsr_checker
  import bsr_pkg::*;
#(
  parameter int BITS = BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [INDEX_W-1:0]  start_index,
  input  logic [COUNT_W-1:0]  bit_count,
  input  logic [INDEX_W-1:0]  dest_index,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                found,
  input  logic [OFFSET_W-1:0] found_offset,
  input  logic                status,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                status;
  } bsr_result_t;

  logic [BITS-1:0] shadow_map;
  bsr_result_t     result_queue[$];

  assign pending = result_queue.size();

  function automatic bsr_result_t apply_request(logic [KIND_W-1:0] k,
      int s, int n, int d);
    bsr_result_t     r;
    logic [BITS-1:0] src;
    bit              want;
    int              off;
    r = '0;
    if (k == K_NONE || n == 0) return r;
    if (s + n > BITS || (k == K_COPY && d + n > BITS)) begin
      r.status = 1'b1;
      return r;
    end
    case (kind_t'(k))
      K_FIRST_SET, K_LAST_SET, K_FIRST_CLEAR, K_LAST_CLEAR: begin
        want = (k == K_FIRST_SET || k == K_LAST_SET);
        for (int i = 0; i < n; i++) begin
          off = (k == K_LAST_SET || k == K_LAST_CLEAR) ? n - 1 - i : i;
          if (shadow_map[s + off] == want) begin
            r.found  = 1'b1;
            r.offset = off[OFFSET_W-1:0];
            break;
          end
        end
      end
      K_SET, K_CLEAR:
        for (int i = 0; i < n; i++) shadow_map[s + i] = (k == K_SET);
      default: begin
        // read the whole source first so overlap cannot corrupt it
        src = shadow_map;
        for (int i = 0; i < n; i++) shadow_map[d + i] = src[s + i];
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    bsr_result_t got, exp_r;
    if (rst) begin
      shadow_map = '0;
      result_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        result_queue.push_back(apply_request(kind, start_index, bit_count, dest_index));
      if (out_valid && !out_stall) begin
        got = '{found, found_offset, status};
        if (result_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch: expected found=%0d offset=%0d status=%0d, got %0d %0d %0d",
                       exp_r.found, exp_r.offset, exp_r.status,
                       got.found, got.offset, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random bitmap requests with random idling on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import bsr_pkg::*;

  localparam int BITS      = BITS_DEF;
  localparam int N_RANDOM  = 1730;
  localparam int CYCLE_CAP = 20000000;

  logic                clk = 0;
  logic                rst = 1;
  logic                in_valid = 0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = '0;
  logic [INDEX_W-1:0]  start_index = '0;
  logic [COUNT_W-1:0]  bit_count = '0;
  logic [INDEX_W-1:0]  dest_index = '0;
  logic                out_valid;
  logic                out_stall = 0;
  logic                found;
  logic [OFFSET_W-1:0] found_offset;
  logic                status;
  int                  fail_count, pending;
  int                  cycles = 0;
  bit                  calm = 0;
  bit                  hold_off_req = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  bitmap_scan_and_range_engine DUT (.*);
  bsr_checker #(.BITS(BITS)) u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        held = 1;
        out_stall <= 1;
        repeat (400) @(negedge clk);
        out_stall <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // hold valid after a transfer so the next request can follow directly
  task automatic send(logic [KIND_W-1:0] k, int s, int n, int d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid    <= 1;
    kind        <= k;
    start_index <= s[INDEX_W-1:0];
    bit_count   <= n[COUNT_W-1:0];
    dest_index  <= d[INDEX_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int s, n, d, r;
    logic [KIND_W-1:0] k;
    k = KIND_W'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    s = $urandom_range(0, BITS - 1);
    d = $urandom_range(0, BITS - 1);
    // copies go bit by bit, so keep most of them short
    if (r == 0) n = $urandom_range(0, 2047);
    else if (r < 3) n = $urandom_range(0, BITS);
    else n = $urandom_range(0, (k == K_COPY) ? 40 : 200);
    if (r > 1 && s + n > BITS) s = BITS - n;
    if (r > 1 && k == K_COPY && d + n > BITS) d = BITS - n;
    if (k == K_COPY && r == 3) d = s;
    send(k, s, n, d);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 0;
    // directed: empty map, extremes, each operation and special case
    send(K_FIRST_SET, 0, BITS, 0);
    send(K_FIRST_CLEAR, 1023, 1, 0);
    send(K_SET, 0, 1, 0);
    send(K_SET, 1023, 1, 0);
    send(K_SET, 70, 200, 0);
    send(K_FIRST_SET, 1, 1023, 0);
    send(K_LAST_SET, 0, BITS, 0);
    send(K_FIRST_CLEAR, 0, BITS, 0);
    send(K_LAST_CLEAR, 0, BITS, 0);
    send(K_LAST_SET, 300, 500, 0);
    send(K_SET, 0, 0, 0);
    send(K_FIRST_SET, 1023, 2, 0);
    send(K_SET, 1, 2047, 0);
    send(K_COPY, 60, 20, 1010);
    send(K_COPY, 60, 30, 65);
    send(K_COPY, 80, 30, 75);
    send(K_COPY, 100, 40, 100);
    send(K_NONE, 1023, 2047, 1023);
    send(K_CLEAR, 0, BITS, 0);
    send(K_SET, 0, BITS, 0);
    send(K_FIRST_CLEAR, 0, BITS, 0);
    send(K_LAST_CLEAR, 5, 7, 0);
    send(K_CLEAR, 512, 512, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        // long receiver hold-off while requests keep coming
        in_valid <= 0;
        hold_off_req = 1;
        repeat (3) @(negedge clk);
      end
      if (i == 600) begin
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      if (i == N_RANDOM - 150) calm = 1;
      send_random();
    end
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- bitmap_scan_and_range_engine.f -----
sv/bsr_pkg.sv
sv/bsr_mem.sv
sv/bitmap_scan_and_range_engine.sv
tb/bsr_checker.sv
tb/testbench.sv
